// ----- src/gcb_pkg.sv -----
package gcb_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 20;
   localparam int CORDIC_STEPS_DEF    = 24;

   // binary angles, 2^32 units per turn
   localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
   localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
   localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

   localparam logic [31:0] INV_GAIN_Q30  = 32'd652032874;
   localparam logic [24:0] BEARING_SCALE = 25'd23592960;

   // exact reciprocal division by 360 for dividends below 2^25
   localparam int          DIV_W       = 25;
   localparam int          RECIP_W     = 26;
   localparam int          DIV_PROD_W  = DIV_W + RECIP_W;
   localparam int          RECIP_SHIFT = 34;
   localparam logic [25:0] RECIP_360   = 26'd47721859;
   localparam logic [8:0]  DEG_TURN    = 9'd360;
   localparam logic [31:0] DEG_HALF    = 32'd180;

   // atan(2^-i) in binary angle units
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic ok;
      logic lat_eq;
      logic turn;
      logic zero;
   } tag_type;

endpackage

// ----- src/gcb_deg2bam.sv -----
// degrees to binary angle, seven stages
module gcb_deg2bam #(
   parameter int ANGLE_FRAC_BITS = gcb_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [29:0] deg,
   output logic        [31:0] bam,
   output logic               turn
);

   localparam int DW = gcb_pkg::DIV_W;
   localparam int PW = gcb_pkg::DIV_PROD_W;
   localparam int RS = gcb_pkg::RECIP_SHIFT;

   logic [29:0]   mag;
   logic [DW-1:0] u1_ff, u2_ff;
   logic [31:0]   t1_ff, t2_ff, t3_ff;
   logic          neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [PW-1:0] p2_ff, p4_ff, p6_ff;
   logic [16:0]   q3;
   logic [DW-1:0] r3_full;
   logic [8:0]    r3_ff;
   logic          turn3_ff, turn4_ff, turn5_ff, turn6_ff, turn_ff;
   logic [DW-1:0] n1, n1_4_ff, r5_full, n2;
   logic [15:0]   tlo4_ff, tlo5_ff, q1, q1_5_ff, q1_6_ff, q2;
   logic [8:0]    r1_5_ff;
   logic [31:0]   b7, bam_ff;

   assign mag = deg[29] ? 30'(-deg) : 30'(deg);

   // split off whole degrees, keep the fraction scaled to 2^32 with half a step
   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= deg[29];
         u1_ff   <= DW'(mag >> ANGLE_FRAC_BITS);
         t1_ff   <= (32'(mag[ANGLE_FRAC_BITS-1:0]) << (32 - ANGLE_FRAC_BITS))
                    + gcb_pkg::DEG_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff   <= PW'(u1_ff) * PW'(gcb_pkg::RECIP_360);
         u2_ff   <= u1_ff;
         t2_ff   <= t1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // whole degrees modulo 360
   assign q3      = p2_ff[PW-1:RS];
   assign r3_full = u2_ff - DW'(q3) * DW'(gcb_pkg::DEG_TURN);

   always_ff @(posedge clock) begin
      if (en) begin
         r3_ff    <= r3_full[8:0];
         t3_ff    <= t2_ff;
         neg3_ff  <= neg2_ff;
         turn3_ff <= (r3_full == '0) && (t2_ff == gcb_pkg::DEG_HALF);
      end
   end

   // long division by 360, upper half
   assign n1 = {r3_ff, t3_ff[31:16]};

   always_ff @(posedge clock) begin
      if (en) begin
         p4_ff    <= PW'(n1) * PW'(gcb_pkg::RECIP_360);
         n1_4_ff  <= n1;
         tlo4_ff  <= t3_ff[15:0];
         neg4_ff  <= neg3_ff;
         turn4_ff <= turn3_ff;
      end
   end

   assign q1      = p4_ff[RS+15:RS];
   assign r5_full = n1_4_ff - DW'(q1) * DW'(gcb_pkg::DEG_TURN);

   always_ff @(posedge clock) begin
      if (en) begin
         q1_5_ff  <= q1;
         r1_5_ff  <= r5_full[8:0];
         tlo5_ff  <= tlo4_ff;
         neg5_ff  <= neg4_ff;
         turn5_ff <= turn4_ff;
      end
   end

   // lower half
   assign n2 = {r1_5_ff, tlo5_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         p6_ff    <= PW'(n2) * PW'(gcb_pkg::RECIP_360);
         q1_6_ff  <= q1_5_ff;
         neg6_ff  <= neg5_ff;
         turn6_ff <= turn5_ff;
      end
   end

   assign q2 = p6_ff[RS+15:RS];
   assign b7 = {q1_6_ff, q2};

   always_ff @(posedge clock) begin
      if (en) begin
         bam_ff  <= neg6_ff ? (32'd0 - b7) : b7;
         turn_ff <= turn6_ff;
      end
   end

   assign bam  = bam_ff;
   assign turn = turn_ff;

endmodule

// ----- src/gcb_sincos.sv -----
// rotation mode cordic, one iteration per stage
module gcb_sincos #(
   parameter int CORDIC_STEPS = gcb_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic        [31:0] angle,
   output logic signed [31:0] sin_q,
   output logic signed [31:0] cos_q
);

   localparam int XW = 34;

   logic signed [XW-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [XW-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [XW-1:0] z_ff [0:CORDIC_STEPS];
   logic                 flip_ff [0:CORDIC_STEPS];
   logic                 flip;
   logic        [31:0]   a_rot;
   logic signed [31:0]   sin_ff, cos_ff;

   // fold the left half plane onto the right one
   assign flip  = (angle > gcb_pkg::TURN_QUARTER) && (angle < gcb_pkg::TURN_3QUARTER);
   assign a_rot = flip ? (angle + gcb_pkg::TURN_HALF) : angle;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= XW'($signed(gcb_pkg::INV_GAIN_Q30));
         y_ff[0]    <= '0;
         z_ff[0]    <= XW'($signed(a_rot));
         flip_ff[0] <= flip;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[k+1] <= flip_ff[k];
            if (!z_ff[k][XW-1]) begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - $signed(XW'(gcb_pkg::ATAN_TAB[k]));
            end else begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + $signed(XW'(gcb_pkg::ATAN_TAB[k]));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= flip_ff[CORDIC_STEPS] ? 32'(-x_ff[CORDIC_STEPS])
                                         : 32'(x_ff[CORDIC_STEPS]);
         sin_ff <= flip_ff[CORDIC_STEPS] ? 32'(-y_ff[CORDIC_STEPS])
                                         : 32'(y_ff[CORDIC_STEPS]);
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

// ----- src/gcb_atan2.sv -----
// vectoring mode cordic, one iteration per stage
module gcb_atan2 #(
   parameter int CORDIC_STEPS = gcb_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] x_in,
   input  logic signed [33:0] y_in,
   output logic        [31:0] angle,
   output logic               zero
);

   localparam int AW = 36;

   logic signed [AW-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [AW-1:0] y_ff [0:CORDIC_STEPS];
   logic        [31:0]   z_ff [0:CORDIC_STEPS];
   logic                 zero_ff [0:CORDIC_STEPS];
   logic signed [AW-1:0] xe, ye;

   assign xe = AW'(x_in);
   assign ye = AW'(y_in);

   // mirror the left half plane
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in[33]) begin
            x_ff[0] <= -xe;
            y_ff[0] <= -ye;
            z_ff[0] <= gcb_pkg::TURN_HALF;
         end else begin
            x_ff[0] <= xe;
            y_ff[0] <= ye;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[k+1] <= zero_ff[k];
            if (!y_ff[k][AW-1] && (y_ff[k] != '0)) begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + gcb_pkg::ATAN_TAB[k];
            end else begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - gcb_pkg::ATAN_TAB[k];
            end
         end
      end
   end

   assign angle = z_ff[CORDIC_STEPS];
   assign zero  = zero_ff[CORDIC_STEPS];

endmodule

// ----- src/great_circle_bearing.sv -----
// throughput: one item per cycle; every stage advances together, held only while
//   the result register is full and not being taken
// reset: synchronous, clears the valid bits of all stages and of the result register
//   and holds req_ready low; data registers are not reset
module great_circle_bearing #(
   parameter int ANGLE_FRAC_BITS = gcb_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = gcb_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [28:0] req_lat_a,
   input  logic signed [28:0] req_lon_a,
   input  logic signed [28:0] req_lat_b,
   input  logic signed [28:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [24:0] rsp_bearing,
   output logic               rsp_coords_ok
);

   // register count of each section, and stage index of the last register of each section
   localparam int LAT_D2B = 7;
   localparam int LAT_SC  = CORDIC_STEPS + 2;
   localparam int LAT_MUL = 4;
   localparam int LAT_AT  = CORDIC_STEPS + 1;
   localparam int IDX_D2B = LAT_D2B;
   localparam int IDX_SC  = IDX_D2B + LAT_SC;
   localparam int IDX_XY  = IDX_SC + LAT_MUL;
   localparam int IDX_AT  = IDX_XY + LAT_AT;
   localparam int IDX_F1  = IDX_AT + 1;
   localparam int NTAG    = IDX_F1 + 1;

   localparam logic signed [33:0] LAT_LIM = 34'sd90 <<< ANGLE_FRAC_BITS;
   localparam logic signed [33:0] LON_LIM = 34'sd180 <<< ANGLE_FRAC_BITS;

   logic                  pipe_en;
   logic                  vld_ff [0:NTAG-1];
   gcb_pkg::tag_type      tag_ff [0:NTAG-1];
   logic                  rsp_valid_ff;
   logic [24:0]           rsp_bearing_ff;
   logic                  rsp_coords_ok_ff;

   logic signed [33:0]    la_w, lb_w, oa_w, ob_w;
   logic                  ok_in;
   logic signed [29:0]    lat_a_ff, lat_b_ff, dlon_ff;

   logic [31:0]           bam_a, bam_b, bam_d;
   logic                  turn_d;
   logic signed [31:0]    sa, ca, sb, cb, sd, cd;

   logic signed [63:0]    py_ff, pt_ff, pc_ff, pt3_ff;
   logic signed [31:0]    cd1_ff, cd2_ff, y2_ff, t2_ff, c2_ff, y3_ff, c3_ff;
   logic signed [33:0]    x4_ff, y4_ff;

   logic [31:0]           at_angle;
   logic                  at_zero;
   logic [56:0]           pb_ff;
   logic [56:0]           rounded;
   logic [24:0]           bearing_in;
   logic                  force_zero;

   // the whole pipe moves while the result register can take a new item
   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en && !reset;

   // range flags and longitude difference
   assign la_w  = 34'(req_lat_a);
   assign lb_w  = 34'(req_lat_b);
   assign oa_w  = 34'(req_lon_a);
   assign ob_w  = 34'(req_lon_b);
   assign ok_in = (la_w >= -LAT_LIM) && (la_w <= LAT_LIM) &&
                  (lb_w >= -LAT_LIM) && (lb_w <= LAT_LIM) &&
                  (oa_w >= -LON_LIM) && (oa_w <= LON_LIM) &&
                  (ob_w >= -LON_LIM) && (ob_w <= LON_LIM);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lat_a_ff <= 30'(req_lat_a);
         lat_b_ff <= 30'(req_lat_b);
         dlon_ff  <= 30'(req_lon_b) - 30'(req_lon_a);
      end
   end

   // valid bits, one per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTAG; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < NTAG; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[NTAG-1];
      end
   end

   // per-item flags ride along; some are filled in where they become known
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         tag_ff[0] <= '{ok: ok_in, lat_eq: (req_lat_a == req_lat_b), turn: 1'b0,
                        zero: 1'b0};
         for (int i = 1; i < NTAG; i++) begin
            if (i == IDX_D2B + 1) begin
               tag_ff[i] <= '{ok: tag_ff[i-1].ok, lat_eq: tag_ff[i-1].lat_eq,
                              turn: turn_d, zero: tag_ff[i-1].zero};
            end else if (i == IDX_F1) begin
               tag_ff[i] <= '{ok: tag_ff[i-1].ok, lat_eq: tag_ff[i-1].lat_eq,
                              turn: tag_ff[i-1].turn, zero: at_zero};
            end else begin
               tag_ff[i] <= tag_ff[i-1];
            end
         end
      end
   end

   // degrees to binary angle
   gcb_deg2bam #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2b_a (
      .clock(clock), .en(pipe_en), .deg(lat_a_ff), .bam(bam_a), .turn()
   );
   gcb_deg2bam #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2b_b (
      .clock(clock), .en(pipe_en), .deg(lat_b_ff), .bam(bam_b), .turn()
   );
   gcb_deg2bam #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2b_d (
      .clock(clock), .en(pipe_en), .deg(dlon_ff), .bam(bam_d), .turn(turn_d)
   );

   // sines and cosines
   gcb_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_a (
      .clock(clock), .en(pipe_en), .angle(bam_a), .sin_q(sa), .cos_q(ca)
   );
   gcb_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_b (
      .clock(clock), .en(pipe_en), .angle(bam_b), .sin_q(sb), .cos_q(cb)
   );
   gcb_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_d (
      .clock(clock), .en(pipe_en), .angle(bam_d), .sin_q(sd), .cos_q(cd)
   );

   // y = sd*cb, x = ca*sb - (sa*cb)*cd, all q30, floor on rescale
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         py_ff  <= 64'(sd) * 64'(cb);
         pt_ff  <= 64'(sa) * 64'(cb);
         pc_ff  <= 64'(ca) * 64'(sb);
         cd1_ff <= cd;

         y2_ff  <= 32'(py_ff >>> 30);
         t2_ff  <= 32'(pt_ff >>> 30);
         c2_ff  <= 32'(pc_ff >>> 30);
         cd2_ff <= cd1_ff;

         pt3_ff <= 64'(t2_ff) * 64'(cd2_ff);
         y3_ff  <= y2_ff;
         c3_ff  <= c2_ff;

         x4_ff  <= 34'(c3_ff) - 34'(pt3_ff >>> 30);
         y4_ff  <= 34'(y3_ff);
      end
   end

   gcb_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan (
      .clock(clock), .en(pipe_en), .x_in(x4_ff), .y_in(y4_ff),
      .angle(at_angle), .zero(at_zero)
   );

   // binary angle to degrees with 16 fraction bits, rounded
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pb_ff <= 57'(at_angle) * 57'(gcb_pkg::BEARING_SCALE);
      end
   end

   assign rounded    = pb_ff + 57'(gcb_pkg::TURN_HALF);
   assign force_zero = tag_ff[IDX_F1].zero ||
                       (tag_ff[IDX_F1].lat_eq && tag_ff[IDX_F1].turn) ||
                       (rounded[56:32] >= gcb_pkg::BEARING_SCALE);
   assign bearing_in = force_zero ? '0 : rounded[56:32];

   // result register
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_bearing_ff   <= bearing_in;
         rsp_coords_ok_ff <= tag_ff[IDX_F1].ok;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bearing   = rsp_bearing_ff;
   assign rsp_coords_ok = rsp_coords_ok_ff;

   // bearing stays below a full circle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bearing < gcb_pkg::BEARING_SCALE))
      else $error("bearing out of range");

   // a held result freezes the last stage behind it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(vld_ff[NTAG-1]) && $stable(pb_ff))
      else $error("pipeline moved during stall");

   // the first and last valid bits and the result valid are clear right after reset
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !vld_ff[0] && !vld_ff[NTAG-1]))
      else $error("valid bits not cleared by reset");

endmodule

// ----- test/tb_great_circle_bearing.sv -----
`timescale 1ns / 1ps

module tb_great_circle_bearing;

   localparam int FRAC  = gcb_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int STEPS = gcb_pkg::CORDIC_STEPS_DEF;
   // block latency plus margin, used for the drain at the end
   localparam int DRAIN = 2 * STEPS + 16 + 20;
   localparam longint LAT_LIM = 90 * (64'sd1 <<< FRAC);
   localparam longint LON_LIM = 180 * (64'sd1 <<< FRAC);
   localparam longint unsigned DEG_DEN = 64'd360 << FRAC;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [28:0] req_lat_a = 0, req_lon_a = 0, req_lat_b = 0, req_lon_b = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [24:0] rsp_bearing;
   logic rsp_coords_ok;

   typedef struct packed {
      logic [24:0] bearing;
      logic        ok;
   } heading_type;

   heading_type heading_q[$];   // expected headings, oldest first
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   great_circle_bearing dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_lat_a, .req_lon_a, .req_lat_b, .req_lon_b,
      .rsp_valid, .rsp_ready, .rsp_bearing, .rsp_coords_ok
   );

   always #5 clock = ~clock;

   // ---------------- heading predictor ----------------

   // degrees in fixed point to a binary angle, round half away from zero
   function automatic logic [31:0] to_binang(longint d);
      longint unsigned mag, q;
      mag = d < 0 ? longint'(-d) : d;
      q = ((mag << 32) + DEG_DEN / 2) / DEG_DEN;
      return d < 0 ? 32'(-q[31:0]) : q[31:0];
   endfunction

   // rotation-mode cordic giving sine and cosine in Q30
   task automatic rot_sincos(input logic [31:0] ang, output longint s, output longint c);
      logic flip;
      longint vx, vy, vz, nx;
      flip = 0;
      vx = gcb_pkg::INV_GAIN_Q30;
      vy = 0;
      // fold the left half-plane onto the right and negate at the end
      if (ang > gcb_pkg::TURN_QUARTER && ang < gcb_pkg::TURN_3QUARTER) begin
         ang = ang + gcb_pkg::TURN_HALF;
         flip = 1;
      end
      vz = longint'($signed(ang));
      for (int i = 0; i < STEPS && i < 32; i++) begin
         if (vz >= 0) begin
            nx = vx - (vy >>> i);
            vy = vy + (vx >>> i);
            vz = vz - longint'(gcb_pkg::ATAN_TAB[i]);
         end else begin
            nx = vx + (vy >>> i);
            vy = vy - (vx >>> i);
            vz = vz + longint'(gcb_pkg::ATAN_TAB[i]);
         end
         vx = nx;
      end
      c = flip ? -vx : vx;
      s = flip ? -vy : vy;
   endtask

   // vectoring-mode cordic giving the angle of (x, y) as a binary angle
   function automatic logic [31:0] vec_angle(longint vy, longint vx);
      logic [31:0] z;
      longint nx;
      z = 0;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         z = gcb_pkg::TURN_HALF;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> i);
            vy = vy - (vx >>> i);
            z = z + gcb_pkg::ATAN_TAB[i];
         end else begin
            nx = vx - (vy >>> i);
            vy = vy + (vx >>> i);
            z = z - gcb_pkg::ATAN_TAB[i];
         end
         vx = nx;
      end
      return z;
   endfunction

   task automatic predict_heading(input logic signed [28:0] la, oa, lb, ob,
                                  output heading_type h);
      longint dl, sa, ca, sb, cb, sd, cd, x, y, t;
      longint unsigned dmag, b, br;
      dl = longint'(ob) - longint'(oa);
      dmag = dl < 0 ? longint'(-dl) : dl;
      h.ok = (la >= -LAT_LIM && la <= LAT_LIM && lb >= -LAT_LIM && lb <= LAT_LIM &&
              oa >= -LON_LIM && oa <= LON_LIM && ob >= -LON_LIM && ob <= LON_LIM);
      br = 0;
      // coincident points give north
      if (!(la == lb && dmag % DEG_DEN == 0)) begin
         rot_sincos(to_binang(la), sa, ca);
         rot_sincos(to_binang(lb), sb, cb);
         rot_sincos(to_binang(dl), sd, cd);
         y = (sd * cb) >>> 30;
         t = (sa * cb) >>> 30;
         x = ((ca * sb) >>> 30) - ((t * cd) >>> 30);
         // zero vector also gives north
         if (x != 0 || y != 0) begin
            b = vec_angle(y, x);
            br = (b * 64'(gcb_pkg::BEARING_SCALE) + 64'h8000_0000) >> 32;
            if (br >= gcb_pkg::BEARING_SCALE) br = 0;
         end
      end
      h.bearing = br[24:0];
   endtask

   // ---------------- reporting and checking ----------------

   task automatic report_mismatch(input string what);
      $display("error at %0t: %s", $realtime, what);
      errors++;
   endtask

   // handshake inputs only change at the rising edge, so the falling edge
   // sees exactly what the next rising edge will accept
   always @(negedge clock) begin
      heading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (heading_q.size() == 0) begin
            report_mismatch("result item with no expected heading");
         end else begin
            want = heading_q.pop_front();
            if (rsp_bearing !== want.bearing)
               report_mismatch($sformatf("bearing %0d, expected %0d",
                                         rsp_bearing, want.bearing));
            if (rsp_coords_ok !== want.ok)
               report_mismatch($sformatf("coords_ok %0b, expected %0b",
                                         rsp_coords_ok, want.ok));
         end
      end
   end

   // result side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // ---------------- stimulus ----------------

   // called just after a rising edge; returns just after the accepting edge
   task automatic send_pair(input logic signed [28:0] la, oa, lb, ob);
      heading_type h;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1;
      req_lat_a <= la;
      req_lon_a <= oa;
      req_lat_b <= lb;
      req_lon_b <= ob;
      @(negedge clock);
      while (!req_ready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      predict_heading(la, oa, lb, ob, h);
      heading_q.insert(heading_q.size(), h);
   endtask

   function automatic logic signed [28:0] deg(int d);
      return 29'(longint'(d) <<< FRAC);
   endfunction

   function automatic logic signed [28:0] rnd_in(longint lim);
      return 29'($urandom_range(2 * lim) - lim);
   endfunction

   function automatic logic signed [28:0] rnd_any();
      return 29'($urandom);
   endfunction

   task automatic test_extremes();
      logic signed [28:0] lo, hi;
      lo = 29'sh1000_0000;
      hi = 29'sh0FFF_FFFF;
      send_pair(deg(-90), deg(-180), deg(90), deg(180));
      send_pair(deg(90), deg(180), deg(-90), deg(-180));
      send_pair(lo, lo, hi, hi);
      send_pair(hi, hi, lo, lo);
      send_pair(lo, hi, lo, hi);
      send_pair(0, 0, 0, deg(90));
      send_pair(0, 0, deg(45), 0);
      send_pair(0, 0, 0, deg(-90));
      send_pair(0, 0, deg(-45), 0);
      send_pair(0, deg(-179), 0, deg(179));
      send_pair(29'sd1, 29'sd0, 29'sd0, -29'sd1);
   endtask

   task automatic test_coincident();
      send_pair(0, 0, 0, 0);
      send_pair(deg(37), deg(-122), deg(37), deg(-122));
      // longitude differs by a whole turn
      send_pair(deg(10), deg(-180), deg(10), deg(180));
      send_pair(deg(-20), deg(-200), deg(-20), deg(160));
      send_pair(deg(90), deg(5), deg(90), deg(100));
   endtask

   task automatic test_zero_vector();
      // poles and antipodes drive x and y toward zero
      send_pair(deg(90), 0, deg(-90), 0);
      send_pair(deg(-90), deg(30), deg(90), deg(-60));
      send_pair(0, 0, 0, deg(180));
      send_pair(deg(90), 0, deg(90), deg(180));
   endtask

   task automatic test_out_of_range();
      send_pair(deg(90) + 29'sd1, 0, 0, 0);
      send_pair(0, deg(-180) - 29'sd1, 0, 0);
      send_pair(0, 0, deg(-90) - 29'sd1, 0);
      send_pair(0, 0, 0, deg(180) + 29'sd1);
      send_pair(deg(400), deg(-700), deg(-200), deg(250));
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: send_pair(rnd_any(), rnd_any(), rnd_any(), rnd_any());
            1: begin
               // same latitude, random longitudes
               logic signed [28:0] la;
               la = rnd_in(LAT_LIM);
               send_pair(la, rnd_in(LON_LIM), la, rnd_in(LON_LIM));
            end
            default: send_pair(rnd_in(LAT_LIM), rnd_in(LON_LIM),
                               rnd_in(LAT_LIM), rnd_in(LON_LIM));
         endcase
      end
   endtask

   // receiver holds off long enough for the pipeline to fill and stall input
   task automatic test_backpressure();
      hold_cycles = 300;
      test_random(120);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_idle_pct = 10;
      recv_idle_pct = 51;
      test_extremes();
      test_coincident();
      test_zero_vector();
      test_out_of_range();
      test_random(180);

      send_idle_pct = 51;
      recv_idle_pct = 10;
      test_random(180);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(150);
      req_valid <= 0;

      while (heading_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("great_circle_bearing: match");
      else
         $display("great_circle_bearing: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("great_circle_bearing: mismatch");
      $finish;
   end

endmodule
